// File: rtl/gdh_pkg.sv
`default_nettype none

package gdh_pkg;

  // Grid and number format
  localparam int unsigned GRID_SIZE = 1024;
  localparam int unsigned COORD_W   = $clog2(GRID_SIZE);
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DIST_W    = 19;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Configuration port
  localparam int unsigned METRIC_W = 3;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam logic [ADDR_W-3:0] METRIC_IDX = '0;

  typedef enum logic [METRIC_W-1:0] {
    METRIC_MANHATTAN = 3'd0,
    METRIC_CHEBYSHEV = 3'd1,
    METRIC_EUCLID    = 3'd2,
    METRIC_OCTILE    = 3'd3
  } metric_e;

  // Euclidean datapath: sum of squares, scaled radicand, root and remainder
  localparam int unsigned SQ_W   = 2 * COORD_W + 1;
  localparam int unsigned RAD_W  = SQ_W + 2 * FRAC_BITS;
  localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
  localparam int unsigned RADP_W = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;

  // Root two rounded to nearest at FRAC_BITS fraction bits (from a Q32 value)
  localparam logic [63:0] SQRT2_Q32  = 64'd6074001000;
  localparam logic [63:0] SQRT2_FULL =
    (SQRT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam int unsigned SQRT2_W = FRAC_BITS + 1;
  localparam logic [SQRT2_W-1:0] SQRT2 = SQRT2_W'(SQRT2_FULL);
  localparam int unsigned PROD_W = COORD_W + SQRT2_W;

  // Non-Euclidean results and the final selection width
  localparam int unsigned ALT_W  = COORD_W + FRAC_BITS + 2;
  localparam int unsigned SEL_A  = (ROOT_W > ALT_W) ? ROOT_W : ALT_W;
  localparam int unsigned SEL_W  = (SEL_A > DIST_W) ? SEL_A : DIST_W;

  // Result that rides beside the root pipeline
  typedef struct packed {
    logic             euclid;
    logic [ALT_W-1:0] alt;
  } side_t;

  // Front end output: radicand plus side result
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    side_t            side;
  } front_t;

endpackage

`default_nettype wire

// File: rtl/gdh_front.sv
`default_nettype none

module gdh_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gdh_pkg::METRIC_W-1:0]  metric_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gdh_pkg::COORD_W-1:0]   start_row_i,
  input  logic [gdh_pkg::COORD_W-1:0]   start_col_i,
  input  logic [gdh_pkg::COORD_W-1:0]   goal_row_i,
  input  logic [gdh_pkg::COORD_W-1:0]   goal_col_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gdh_pkg::front_t               out_o
);
  import gdh_pkg::*;

  // Stage 1: absolute differences, larger and smaller
  logic                v1_q;
  logic [COORD_W-1:0]  dr_d, dc_d, dr_q, dc_q, hi_q, lo_q;
  logic [METRIC_W-1:0] metric1_q;

  // Stage 2: squares, sums, root-two product
  logic                v2_q;
  logic [COORD_W:0]    man_q;
  logic [COORD_W-1:0]  cheb_q, diff_q;
  logic [2*COORD_W-1:0] sqr_q, sqc_q;
  logic [PROD_W-1:0]   oct_q;
  logic [METRIC_W-1:0] metric2_q;

  // Stage 3: radicand and finished non-Euclidean result
  logic                v3_q;
  front_t              out_d, out_q;
  logic [SQ_W-1:0]     sq_sum;

  logic rdy1, rdy2, rdy3;

  // Ready chain: a stage moves when it is empty or the next one moves
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign dr_d = (goal_row_i >= start_row_i) ? goal_row_i - start_row_i
                                            : start_row_i - goal_row_i;
  assign dc_d = (goal_col_i >= start_col_i) ? goal_col_i - start_col_i
                                            : start_col_i - goal_col_i;

  // Stage 3 logic
  always_comb begin
    sq_sum          = SQ_W'(sqr_q) + SQ_W'(sqc_q);
    out_d.rad       = RAD_W'(sq_sum) << (2 * FRAC_BITS);
    out_d.side.euclid = 1'b0;
    case (metric_e'(metric2_q))
      METRIC_MANHATTAN: out_d.side.alt = ALT_W'(man_q) << FRAC_BITS;
      METRIC_CHEBYSHEV: out_d.side.alt = ALT_W'(cheb_q) << FRAC_BITS;
      METRIC_OCTILE:    out_d.side.alt = (ALT_W'(diff_q) << FRAC_BITS) + ALT_W'(oct_q);
      METRIC_EUCLID: begin
        out_d.side.alt    = '0;
        out_d.side.euclid = 1'b1;
      end
      default:          out_d.side.alt = '0;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dr_q      <= dr_d;
      dc_q      <= dc_d;
      hi_q      <= (dr_d > dc_d) ? dr_d : dc_d;
      lo_q      <= (dr_d > dc_d) ? dc_d : dr_d;
      metric1_q <= metric_i;
    end
    if (rdy2 && v1_q) begin
      man_q     <= {1'b0, dr_q} + {1'b0, dc_q};
      cheb_q    <= hi_q;
      diff_q    <= hi_q - lo_q;
      sqr_q     <= (2*COORD_W)'(dr_q) * (2*COORD_W)'(dr_q);
      sqc_q     <= (2*COORD_W)'(dc_q) * (2*COORD_W)'(dc_q);
      oct_q     <= PROD_W'(lo_q) * PROD_W'(SQRT2);
      metric2_q <= metric1_q;
    end
    if (rdy3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// File: rtl/gdh_isqrt.sv
`default_nettype none

module gdh_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gdh_pkg::RAD_W-1:0]   rad_i,
  input  gdh_pkg::side_t              side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gdh_pkg::ROOT_W-1:0]  root_o,
  output gdh_pkg::side_t              side_o
);
  import gdh_pkg::*;

  // One root bit per stage, restoring method on radicand bit pairs
  logic                v_q    [ROOT_W];
  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [RADP_W-1:0]   rad_q  [ROOT_W];
  side_t               side_q [ROOT_W];
  logic                rdy    [ROOT_W+1];

  assign rdy[ROOT_W] = out_ready_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [RADP_W-1:0] rad_prev;
    side_t             side_prev;
    logic [REM_W+1:0]  rem_ext;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_prev    = in_valid_i;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = RADP_W'(rad_i);
      assign side_prev = side_i;
    end else begin : g_next
      assign v_prev    = v_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
      assign rad_prev  = rad_q[k-1];
      assign side_prev = side_q[k-1];
    end

    assign rdy[k]  = !v_q[k] || rdy[k+1];
    // bring down the next two radicand bits and try root*4+1
    assign rem_ext = {rem_prev, rad_prev[2*(ROOT_W-1-k)+1 -: 2]};
    assign trial   = (REM_W+2)'({root_prev, 2'b01});
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_prev) begin
        rem_q[k]  <= take ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
        root_q[k] <= {root_prev[ROOT_W-2:0], take};
        rad_q[k]  <= rad_prev;
        side_q[k] <= side_prev;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[ROOT_W-1];
  assign root_o      = root_q[ROOT_W-1];
  assign side_o      = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/grid_distance_heuristic.sv
// Grid distance heuristic: distance from a start cell to a goal cell on a
// square grid, in unsigned fixed point with FRAC_BITS fraction bits.
// The metric register (byte address 0) picks Manhattan, Chebyshev,
// Euclidean (floored) or octile; the other codes give zero. Write it only
// while no item is in flight.
// Input channel: in_valid_i/in_ready_o with the four coordinates. Output
// channel: out_valid_o/out_ready_i with distance_o. One result per item.
// An item passes three front stages (differences, multiplies, radicand),
// one stage per root bit in the square root pipeline, and the output
// register. Throughput is one item per cycle while the receiver does not
// stall; every stage carries a valid bit and moves when it is empty or its
// successor moves.
// When the receiver stalls the result holds in the output register and the
// stages behind it keep filling; in_ready_o falls only when every stage is
// occupied. Reset empties the pipeline and sets the metric to Manhattan.
`default_nettype none

module grid_distance_heuristic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gdh_pkg::ADDR_W-1:0]    paddr,
  input  logic [gdh_pkg::DATA_W-1:0]    pwdata,
  output logic [gdh_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gdh_pkg::COORD_W-1:0]   start_row_i,
  input  logic [gdh_pkg::COORD_W-1:0]   start_col_i,
  input  logic [gdh_pkg::COORD_W-1:0]   goal_row_i,
  input  logic [gdh_pkg::COORD_W-1:0]   goal_col_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gdh_pkg::DIST_W-1:0]    distance_o
);
  import gdh_pkg::*;

  logic [METRIC_W-1:0] metric_q;
  logic                hit;

  front_t              fr;
  logic                fr_valid, fr_ready;
  logic                sq_valid, sq_ready;
  logic [ROOT_W-1:0]   sq_root;
  side_t               sq_side;

  logic                out_valid_q;
  logic [DIST_W-1:0]   dist_d, dist_q;
  logic [SEL_W-1:0]    sel;

  // Register access
  assign hit    = paddr[ADDR_W-1:2] == METRIC_IDX;
  assign pready = 1'b1;
  assign prdata = hit ? DATA_W'(metric_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_MANHATTAN;
    end else if (psel && penable && pwrite && hit) begin
      metric_q <= pwdata[METRIC_W-1:0];
    end
  end

  gdh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .metric_i    (metric_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_row_i (start_row_i),
    .start_col_i (start_col_i),
    .goal_row_i  (goal_row_i),
    .goal_col_i  (goal_col_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr)
  );

  gdh_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .rad_i       (fr.rad),
    .side_i      (fr.side),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  // Output stage: pick root or side result, saturate
  assign sq_ready = !out_valid_q || out_ready_i;
  assign sel      = sq_side.euclid ? SEL_W'(sq_root) : SEL_W'(sq_side.alt);
  assign dist_d   = (sel > SEL_W'(DIST_MAX)) ? DIST_MAX : sel[DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sq_ready) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_ready && sq_valid) begin
      dist_q <= dist_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

  // Back pressure reaches the input only when the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output is free");

  // A held root result stays valid until the output stage takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid && !sq_ready) |=> sq_valid)
    else $error("root pipeline dropped a stalled item");

  // A new result only appears when the root pipeline offered one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(sq_valid))
    else $error("result appeared without a source item");

endmodule

`default_nettype wire

// File: bench/tb_grid_distance_heuristic.sv
`default_nettype none

module tb_grid_distance_heuristic;
  import gdh_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned DIR_ROWS     = 20;
  localparam int unsigned MAX_PRINTS   = 40;

  localparam logic [COORD_W-1:0] CMAX = '1;

  // register map: metric at index 0, index 1 is unmapped
  localparam logic [ADDR_W-1:0] METRIC_ADDR = '0;
  localparam logic [ADDR_W-1:0] SPARE_ADDR  = ADDR_W'(4);

  // metric codes with no defined metric
  localparam logic [METRIC_W-1:0] METRIC_RSVD4 = 3'd4;
  localparam logic [METRIC_W-1:0] METRIC_RSVD5 = 3'd5;
  localparam logic [METRIC_W-1:0] METRIC_RSVD6 = 3'd6;
  localparam logic [METRIC_W-1:0] METRIC_RSVD7 = 3'd7;

  // root two, Q32 rounded to nearest at the output precision
  localparam logic [63:0] ROOT2_Q32 = 64'd6074001000;
  localparam logic [63:0] ROOT2_FX  =
    (ROOT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  typedef struct {
    logic [METRIC_W-1:0] metric;
    logic [COORD_W-1:0]  sr;
    logic [COORD_W-1:0]  sc;
    logic [COORD_W-1:0]  gr;
    logic [COORD_W-1:0]  gc;
    bit                  known;
    logic [DIST_W-1:0]   want;
  } dir_row_t;

  typedef struct {
    bit                known;
    logic [DIST_W-1:0] want;
  } hint_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [COORD_W-1:0]  start_row_i = '0;
  logic [COORD_W-1:0]  start_col_i = '0;
  logic [COORD_W-1:0]  goal_row_i  = '0;
  logic [COORD_W-1:0]  goal_col_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [DIST_W-1:0]   distance_o;

  // testbench state
  bit                  no_idle = 1'b0;
  logic [METRIC_W-1:0] metric_model = METRIC_MANHATTAN;
  logic [DIST_W-1:0]   dist_q[$];
  hint_t               hint_q[$];
  hint_t               hint_now;
  logic [DIST_W-1:0]   dist_exp;
  int unsigned         n_errors  = 0;
  int unsigned         n_items   = 0;
  int unsigned         n_results = 0;
  int unsigned         n_configs = 0;
  int unsigned         cycle_cnt = 0;

  // directed items; expected distance typed in where it is obvious
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{METRIC_MANHATTAN, 0,    0,    0,    0,    1, 0},
    '{METRIC_MANHATTAN, 0,    0,    CMAX, CMAX, 1, 523776},
    '{METRIC_MANHATTAN, CMAX, CMAX, 0,    0,    1, 523776},
    '{METRIC_MANHATTAN, CMAX, 0,    0,    CMAX, 1, 523776},
    '{METRIC_MANHATTAN, 5,    9,    2,    700,  0, 0},
    '{METRIC_CHEBYSHEV, 0,    0,    CMAX, CMAX, 1, 261888},
    '{METRIC_CHEBYSHEV, CMAX, 0,    0,    3,    1, 261888},
    '{METRIC_CHEBYSHEV, 10,   20,   30,   25,   0, 0},
    '{METRIC_EUCLID,    0,    0,    3,    4,    1, 1280},
    '{METRIC_EUCLID,    0,    0,    0,    CMAX, 1, 261888},
    '{METRIC_EUCLID,    0,    0,    CMAX, CMAX, 0, 0},
    '{METRIC_EUCLID,    1,    1,    2,    2,    0, 0},
    '{METRIC_OCTILE,    0,    0,    CMAX, CMAX, 1, 370326},
    '{METRIC_OCTILE,    0,    0,    CMAX, 0,    1, 261888},
    '{METRIC_OCTILE,    7,    3,    2,    9,    0, 0},
    '{METRIC_OCTILE,    CMAX, CMAX, CMAX, CMAX, 1, 0},
    '{METRIC_RSVD4,     0,    0,    CMAX, CMAX, 1, 0},
    '{METRIC_RSVD5,     12,   3,    4,    5,    1, 0},
    '{METRIC_RSVD6,     CMAX, 0,    0,    CMAX, 1, 0},
    '{METRIC_RSVD7,     0,    0,    CMAX, CMAX, 1, 0}
  };

  // metric per random phase; phase 3 runs with no idling on either side
  logic [METRIC_W-1:0] phase_metric [PHASES] = '{
    METRIC_EUCLID, METRIC_OCTILE, METRIC_RSVD7, METRIC_CHEBYSHEV,
    METRIC_MANHATTAN, METRIC_RSVD4, METRIC_EUCLID, METRIC_OCTILE,
    METRIC_RSVD5, METRIC_RSVD6
  };

  grid_distance_heuristic u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_row_i (start_row_i),
    .start_col_i (start_col_i),
    .goal_row_i  (goal_row_i),
    .goal_col_i  (goal_col_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o)
  );

  always #10 clk_i = ~clk_i;

  // floor of the square root, one result bit per step
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // expected distance for one cell pair under the given metric
  function automatic logic [DIST_W-1:0] grid_heuristic(
    input logic [METRIC_W-1:0] m,
    input logic [COORD_W-1:0]  sr,
    input logic [COORD_W-1:0]  sc,
    input logic [COORD_W-1:0]  gr,
    input logic [COORD_W-1:0]  gc
  );
    logic [63:0] dr, dc, hi, lo, d;
    dr = (gr > sr) ? 64'(gr) - 64'(sr) : 64'(sr) - 64'(gr);
    dc = (gc > sc) ? 64'(gc) - 64'(sc) : 64'(sc) - 64'(gc);
    hi = (dr > dc) ? dr : dc;
    lo = (dr > dc) ? dc : dr;
    case (m)
      METRIC_MANHATTAN: d = (dr + dc) << FRAC_BITS;
      METRIC_CHEBYSHEV: d = hi << FRAC_BITS;
      METRIC_EUCLID:    d = floor_sqrt((dr * dr + dc * dc) << (2 * FRAC_BITS));
      METRIC_OCTILE:    d = ((hi - lo) << FRAC_BITS) + lo * ROOT2_FX;
      default:          d = '0;
    endcase
    if (d > 64'(DIST_MAX)) d = 64'(DIST_MAX);
    return d[DIST_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // two-phase APB transfer, then the bus is left idle
  task automatic apb_xfer(input bit wr, input logic [ADDR_W-1:0] a,
                          input logic [DATA_W-1:0] wd, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= wd;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_metric_reg();
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, METRIC_ADDR, '0, rd);
    if (rd !== DATA_W'(metric_model))
      report_mismatch($sformatf("metric reads %0h, expected %0h", rd, metric_model));
  endtask

  // upper data bits are junk; only the low bits hold the code
  task automatic set_metric(input logic [METRIC_W-1:0] code);
    logic [DATA_W-1:0] wd;
    logic [DATA_W-1:0] rd;
    wd = $urandom();
    wd[METRIC_W-1:0] = code;
    apb_xfer(1'b1, METRIC_ADDR, wd, rd);
    n_configs++;
    check_metric_reg();
  endtask

  // drop valid and wait until every accepted item has its result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (dist_q.size() != 0) @(negedge clk_i);
  endtask

  // offer one item after a random gap; returns on the falling edge after acceptance
  task automatic send_item(input logic [COORD_W-1:0] sr, input logic [COORD_W-1:0] sc,
                           input logic [COORD_W-1:0] gr, input logic [COORD_W-1:0] gc,
                           input bit known, input logic [DIST_W-1:0] want);
    hint_t h;
    h.known = known;
    h.want  = want;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    hint_q.push_back(h);
    in_valid_i  <= 1'b1;
    start_row_i <= sr;
    start_col_i <= sc;
    goal_row_i  <= gr;
    goal_col_i  <= gc;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    @(negedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > int'(CMAX)) t = int'(CMAX);
    return COORD_W'(t);
  endfunction

  // random cell pair: uniform half the time, else corners, near pairs, diagonals, same cell
  task automatic pick_item(output logic [COORD_W-1:0] sr, output logic [COORD_W-1:0] sc,
                           output logic [COORD_W-1:0] gr, output logic [COORD_W-1:0] gc);
    int unsigned mode;
    int unsigned span;
    logic [COORD_W-1:0] tmp;
    mode = $urandom_range(0, 99);
    sr = COORD_W'($urandom());
    sc = COORD_W'($urandom());
    gr = COORD_W'($urandom());
    gc = COORD_W'($urandom());
    if (mode < 15) begin
      sr = $urandom_range(0, 1) ? CMAX : '0;
      sc = $urandom_range(0, 1) ? CMAX : '0;
      gr = $urandom_range(0, 1) ? CMAX : '0;
      gc = $urandom_range(0, 1) ? CMAX : '0;
    end else if (mode < 35) begin
      gr = near_coord(sr);
      gc = near_coord(sc);
    end else if (mode < 45) begin
      span = $urandom_range(0, int'(CMAX));
      sr = COORD_W'($urandom_range(0, int'(CMAX) - span));
      sc = COORD_W'($urandom_range(0, int'(CMAX) - span));
      gr = sr + COORD_W'(span);
      gc = sc + COORD_W'(span);
      if ($urandom_range(0, 1)) begin
        tmp = sr; sr = gr; gr = tmp;
      end
    end else if (mode < 50) begin
      gr = sr;
      gc = sc;
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result check, expectation on acceptance, register model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (dist_q.size() == 0) begin
          report_mismatch($sformatf("distance %0d with no item pending", distance_o));
        end else begin
          dist_exp = dist_q.pop_front();
          if (distance_o !== dist_exp)
            report_mismatch($sformatf("result %0d: distance %0d, expected %0d",
                                      n_results, distance_o, dist_exp));
          n_results++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        hint_now = hint_q.pop_front();
        if (hint_now.known) dist_q.push_back(hint_now.want);
        else dist_q.push_back(grid_heuristic(metric_model, start_row_i, start_col_i,
                                             goal_row_i, goal_col_i));
      end
      if (psel && penable && pwrite && pready && paddr == METRIC_ADDR)
        metric_model = pwdata[METRIC_W-1:0];
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", dist_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [COORD_W-1:0] sr, sc, gr, gc;
    logic [DATA_W-1:0]  rd;
    logic [METRIC_W-1:0] cur_metric;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value, then a write to the unmapped index must change nothing
    check_metric_reg();
    apb_xfer(1'b1, SPARE_ADDR, $urandom() | DATA_W'(METRIC_RSVD5), rd);
    check_metric_reg();
    cur_metric = METRIC_MANHATTAN;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].metric != cur_metric) begin
        wait_drained();
        set_metric(dir_tab[i].metric);
        cur_metric = dir_tab[i].metric;
      end
      send_item(dir_tab[i].sr, dir_tab[i].sc, dir_tab[i].gr, dir_tab[i].gc,
                dir_tab[i].known, dir_tab[i].want);
    end

    // random phases, one metric setting each
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      no_idle = (p == 3);
      set_metric(phase_metric[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_item(sr, sc, gr, gc);
        send_item(sr, sc, gr, gc, 1'b0, '0);
      end
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d cell pairs over %0d metric writes (all eight codes, corners, near pairs,",
             n_items, n_configs);
    $display("diagonals, same cell, random stalls both sides); %0d results, %0d mismatches",
             n_results, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/gdh_pkg.sv
rtl/gdh_front.sv
rtl/gdh_isqrt.sv
rtl/grid_distance_heuristic.sv
bench/tb_grid_distance_heuristic.sv
